// ===== rtl/qrt_pkg.sv =====
// Shared constants, types and the rounding Q30 multiply for the rotate-towards pipeline.
package qrt_pkg;

    localparam int FRAC_BITS = 14;

    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [30:0] HALF_PI = 31'd1686629713;

    // Series evaluation: one slot per Horner term, three register stages per slot.
    localparam int TRIG_SLOTS = 8;
    localparam int SIN_TERMS  = 7;
    localparam int TRIG_LAT   = 3 * TRIG_SLOTS + 2;

    // Square roots: 62-bit radicand, 31-bit root, one root bit per stage.
    localparam int SQRT_IN_W = 62;
    localparam int SQRT_W    = SQRT_IN_W / 2;

    // Normalizing divide: quotient never exceeds 2^FRAC_BITS.
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int NUM_W = FRAC_BITS + SQRT_W;

    typedef enum logic [1:0] {
        OC_NONE    = 2'd0,
        OC_REACHED = 2'd1,
        OC_PARTIAL = 2'd2
    } outcome_t;

    // Q30 product, rounded half away from zero.
    function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] p;
        logic [67:0]        mag;
        logic [67:0]        r;
        logic signed [35:0] rs;
        p   = a * b;
        mag = p[67] ? 68'(-p) : 68'(p);
        r   = (mag + (68'd1 << 29)) >> 30;
        rs  = $signed(r[35:0]);
        return p[67] ? -rs : rs;
    endfunction

endpackage

// ===== rtl/qrt_delay.sv =====
// Enabled shift-register delay line for pipeline side bundles.
module qrt_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                pipe_reg[i] <= '0;
            end
        end else if (en) begin
            pipe_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[N-1];

endmodule

// ===== rtl/qrt_trig.sv =====
// Pipelined Horner evaluation of sine and cosine of a Q30 angle up to pi/2.
module qrt_trig (
    input  logic               aclk,
    input  logic               en,
    input  logic [30:0]        x_in,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int DIV_SH = 34;
    localparam int RW     = 35;

    logic [31:0]        x2_s [qrt_pkg::TRIG_SLOTS+1];
    logic [30:0]        x_s  [qrt_pkg::TRIG_SLOTS+1];
    logic signed [31:0] tc_s [qrt_pkg::TRIG_SLOTS+1];
    logic signed [31:0] ts_s [qrt_pkg::TRIG_SLOTS+1];

    logic [30:0]        x0_reg;
    logic [31:0]        x20_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg  <= x_in;
            x20_reg <= 32'(qrt_pkg::mul_q30($signed(34'(x_in)), $signed(34'(x_in))));
        end
    end

    assign x_s[0]  = x0_reg;
    assign x2_s[0] = x20_reg;
    assign tc_s[0] = $signed(qrt_pkg::Q30_ONE);
    assign ts_s[0] = $signed(qrt_pkg::Q30_ONE);

    for (genvar j = 0; j < qrt_pkg::TRIG_SLOTS; j++) begin : g_slot
        localparam int K = qrt_pkg::TRIG_SLOTS - j;
        localparam logic [39:0] DC = 40'((2 * K - 1) * (2 * K));
        localparam logic [39:0] DS = 40'((2 * K) * (2 * K + 1));
        localparam logic [RW-1:0] RC = RW'((66'd1 << DIV_SH) / 66'(DC));
        localparam logic [RW-1:0] RS = RW'((66'd1 << DIV_SH) / 66'(DS));

        logic [32:0]        mc_a_reg, ms_a_reg, mc_b_reg, ms_b_reg;
        logic [67:0]        pc_b_reg, ps_b_reg;
        logic [31:0]        x2_a_reg, x2_b_reg, x2_c_reg;
        logic [30:0]        x_a_reg, x_b_reg, x_c_reg;
        logic signed [31:0] tc_c_reg, ts_c_reg;
        logic [31:0]        qc0, qs0;
        logic [39:0]        rc, rsn;
        logic [31:0]        qc, qs;

        always_comb begin
            qc0 = pc_b_reg[DIV_SH+31:DIV_SH];
            qs0 = ps_b_reg[DIV_SH+31:DIV_SH];
            rc  = 40'(mc_b_reg) - 40'(qc0) * DC;
            rsn = 40'(ms_b_reg) - 40'(qs0) * DS;
            qc  = (rc >= DC) ? qc0 + 32'd1 : qc0;
            qs  = (rsn >= DS) ? qs0 + 32'd1 : qs0;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mc_a_reg <= 33'(qrt_pkg::mul_q30($signed(34'(x2_s[j])), 34'(tc_s[j])));
                ms_a_reg <= 33'(qrt_pkg::mul_q30($signed(34'(x2_s[j])), 34'(ts_s[j])));
                x2_a_reg <= x2_s[j];
                x_a_reg  <= x_s[j];

                pc_b_reg <= 68'(mc_a_reg) * 68'(RC);
                ps_b_reg <= 68'(ms_a_reg) * 68'(RS);
                mc_b_reg <= mc_a_reg;
                ms_b_reg <= ms_a_reg;
                x2_b_reg <= x2_a_reg;
                x_b_reg  <= x_a_reg;

                tc_c_reg <= $signed(qrt_pkg::Q30_ONE - qc);
                ts_c_reg <= (K > qrt_pkg::SIN_TERMS) ? $signed(qrt_pkg::Q30_ONE)
                                                      : $signed(qrt_pkg::Q30_ONE - qs);
                x2_c_reg <= x2_b_reg;
                x_c_reg  <= x_b_reg;
            end
        end

        assign x2_s[j+1] = x2_c_reg;
        assign x_s[j+1]  = x_c_reg;
        assign tc_s[j+1] = tc_c_reg;
        assign ts_s[j+1] = ts_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= tc_s[qrt_pkg::TRIG_SLOTS];
            sin_reg <= 32'(qrt_pkg::mul_q30($signed(34'(x_s[qrt_pkg::TRIG_SLOTS])),
                                            34'(ts_s[qrt_pkg::TRIG_SLOTS])));
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ===== rtl/qrt_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
module qrt_isqrt #(
    parameter int IN_W = 62
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   rad,
    output logic [IN_W/2-1:0] root
);

    localparam int STEPS = IN_W / 2;

    logic [IN_W-1:0] v_s [STEPS+1];
    logic [IN_W-1:0] r_s [STEPS+1];

    assign v_s[0] = rad;
    assign r_s[0] = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (IN_W - 2 - 2 * k);

        logic [IN_W-1:0] v_reg, r_reg;
        logic [IN_W:0]   trial;

        assign trial = (IN_W+1)'(r_s[k]) + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if ((IN_W+1)'(v_s[k]) >= trial) begin
                    v_reg <= IN_W'((IN_W+1)'(v_s[k]) - trial);
                    r_reg <= IN_W'((IN_W+1)'(r_s[k] >> 1) + BIT);
                end else begin
                    v_reg <= v_s[k];
                    r_reg <= r_s[k] >> 1;
                end
            end
        end

        assign v_s[k+1] = v_reg;
        assign r_s[k+1] = r_reg;
    end

    assign root = r_s[STEPS][IN_W/2-1:0];

endmodule

// ===== rtl/qrt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qrt_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 31,
    parameter int QUO_W = 15
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int SW = DEN_W + QUO_W;

    logic [SW-1:0]    rem_s [QUO_W+1];
    logic [DEN_W-1:0] den_s [QUO_W+1];
    logic [QUO_W-1:0] q_s   [QUO_W+1];

    assign rem_s[0] = SW'(num);
    assign den_s[0] = den;
    assign q_s[0]   = '0;

    for (genvar i = 0; i < QUO_W; i++) begin : g_bit
        localparam int B = QUO_W - 1 - i;

        logic [SW-1:0]    rem_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QUO_W-1:0] q_reg;
        logic [SW-1:0]    dsh;

        assign dsh = SW'(den_s[i]) << B;

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg <= den_s[i];
                if (rem_s[i] >= dsh) begin
                    rem_reg <= rem_s[i] - dsh;
                    q_reg   <= q_s[i] | (QUO_W'(1) << B);
                end else begin
                    rem_reg <= rem_s[i];
                    q_reg   <= q_s[i];
                end
            end
        end

        assign rem_s[i+1] = rem_reg;
        assign den_s[i+1] = den_reg;
        assign q_s[i+1]   = q_reg;
    end

    assign quo = q_s[QUO_W];

endmodule

// ===== rtl/quaternion_rotate_towards_limited_core.sv =====
// Top level: turns a quaternion toward a target by at most a step angle, fully pipelined.
// The square roots and the dividers make up most of the path from request acceptance to m_tvalid.
// Throughput is one request per cycle; the whole pipeline advances together whenever the
// output register is empty or being drained, so a stall freezes every stage in place.
// Reset (aresetn low, synchronous) clears all valid bits; no clearing pass is needed.
module quaternion_rotate_towards_limited_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: cur_w, cur_x, cur_y, cur_z, tgt_w, tgt_x, tgt_y, tgt_z,
    // step_limit (16 bits each)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: res_w, res_x, res_y, res_z (16 bits each)
    output logic [63:0]  m_tdata,
    // m_tuser from bit 0: outcome (2 bits)
    output logic [1:0]   m_tuser
);

    localparam int F = qrt_pkg::FRAC_BITS;

    // Dot product has 2F fraction bits; these constants place the "close enough" threshold
    // and the conversion of the dot product to Q30.
    localparam logic [63:0] FULL    = 64'd1 << (2 * F);
    localparam logic [63:0] NEAR_TH = FULL - FULL / 64'd10000;
    localparam int          SH_R    = (2 * F >= 30) ? 2 * F - 30 : 0;
    localparam int          SH_L    = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam int          L_SH    = 30 - F;

    localparam int PH_LAT   = 1 + qrt_pkg::SQRT_W;
    localparam int TRIG_PAD = PH_LAT - qrt_pkg::TRIG_LAT;

    typedef struct packed {
        logic                  vld;
        logic [3:0][15:0]      cur;
        logic [3:0][15:0]      tgt;
        qrt_pkg::outcome_t     oc;
    } base_t;

    typedef struct packed {
        base_t            b;
        logic [3:0][16:0] curn;
        logic [30:0]      c;
        logic             dec;
    } ph_t;

    typedef struct packed {
        base_t            b;
        logic [3:0]       sgn;
        logic [3:0][29:0] mag;
    } tail_t;

    typedef struct packed {
        base_t      b;
        logic [3:0] sgn;
        logic       nz;
    } fin_t;

    // The whole pipeline moves when the output register can take a new result.
    logic pipe_en;
    logic m_tvalid_reg;
    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;

    // ---------------------------------------------------------------- stage 1: dot product
    logic             st1_vld_reg;
    logic [3:0][15:0] st1_cur_reg, st1_tgt_reg;
    logic [15:0]      st1_lim_reg;
    logic signed [33:0] st1_d_reg;
    logic             st1_nostep_reg;
    logic signed [33:0] dot_next;
    logic [15:0]        lim_in;

    assign lim_in = s_tdata[143:128];

    always_comb begin
        dot_next = '0;
        for (int i = 0; i < 4; i++) begin
            dot_next = dot_next + 34'($signed(s_tdata[16*i +: 16]) *
                                      $signed(s_tdata[64+16*i +: 16]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            st1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 4; i++) begin
                st1_cur_reg[i] <= s_tdata[16*i +: 16];
                st1_tgt_reg[i] <= s_tdata[64+16*i +: 16];
            end
            st1_lim_reg    <= lim_in;
            st1_d_reg      <= dot_next;
            // Limit below 0.001 tested exactly as limit * 1000 < 1.0.
            st1_nostep_reg <= (32'(lim_in) * 32'd1000) < (32'd1 << F);
        end
    end

    // ------------------------------------------- stage 2: early decisions and short path
    ph_t         st2_next, st2_reg;
    logic [30:0] x_next, x_reg;
    logic [33:0] dm;
    logic [63:0] dm64, l30;
    logic        near, big;

    always_comb begin
        dm   = st1_d_reg[33] ? 34'(-st1_d_reg) : 34'(st1_d_reg);
        dm64 = 64'(dm);
        near = !st1_d_reg[33] && (dm64 >= NEAR_TH);
        l30  = 64'(st1_lim_reg) << L_SH;
        big  = l30 > 64'(qrt_pkg::HALF_PI);
        x_next = big ? qrt_pkg::HALF_PI : l30[30:0];

        st2_next.b.vld = st1_vld_reg;
        st2_next.b.cur = st1_cur_reg;
        st2_next.b.tgt = st1_tgt_reg;
        for (int i = 0; i < 4; i++) begin
            // Negative dot product: flip current to take the short arc.
            st2_next.curn[i] = st1_d_reg[33] ? 17'(-$signed(st1_cur_reg[i]))
                                             : 17'($signed(st1_cur_reg[i]));
        end
        if (dm64 >= FULL) begin
            st2_next.c = 31'(qrt_pkg::Q30_ONE);
        end else begin
            st2_next.c = 31'((dm64 >> SH_R) << SH_L);
        end
        st2_next.dec = st1_nostep_reg || near || big;
        if (st1_nostep_reg) begin
            st2_next.b.oc = qrt_pkg::OC_NONE;
        end else if (near || big) begin
            st2_next.b.oc = qrt_pkg::OC_REACHED;
        end else begin
            st2_next.b.oc = qrt_pkg::OC_PARTIAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg.b.vld <= 1'b0;
        end else if (pipe_en) begin
            st2_reg.b.vld <= st2_next.b.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st2_reg.b.cur <= st2_next.b.cur;
            st2_reg.b.tgt <= st2_next.b.tgt;
            st2_reg.b.oc  <= st2_next.b.oc;
            st2_reg.curn  <= st2_next.curn;
            st2_reg.c     <= st2_next.c;
            st2_reg.dec   <= st2_next.dec;
            x_reg         <= x_next;
        end
    end

    // ------------------------------ phase: sin/cos of the limit, sin of remaining angle
    logic [qrt_pkg::SQRT_IN_W-1:0] rad_reg;
    logic [qrt_pkg::SQRT_W-1:0]    s_root;
    logic signed [31:0]            cl_raw, sl_raw;
    logic [63:0]                   trig_d;
    logic signed [31:0]            cl, sl;
    ph_t                           ph;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rad_reg <= qrt_pkg::SQRT_IN_W'((64'd1 << 60) - 64'(st2_reg.c) * 64'(st2_reg.c));
        end
    end

    qrt_isqrt #(.IN_W(qrt_pkg::SQRT_IN_W)) u_sqrt_sin (
        .aclk (aclk),
        .en   (pipe_en),
        .rad  (rad_reg),
        .root (s_root)
    );

    qrt_trig u_trig (
        .aclk    (aclk),
        .en      (pipe_en),
        .x_in    (x_reg),
        .cos_out (cl_raw),
        .sin_out (sl_raw)
    );

    qrt_delay #(.W(64), .N(TRIG_PAD)) u_trig_pad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .din     ({cl_raw, sl_raw}),
        .dout    (trig_d)
    );

    assign cl = $signed(trig_d[63:32]);
    assign sl = $signed(trig_d[31:0]);

    qrt_delay #(.W($bits(ph_t)), .N(PH_LAT)) u_ph_pad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .din     (st2_reg),
        .dout    (ph)
    );

    // ------------------------------------------------ W1: angle test, weight products
    base_t              w1_reg;
    logic [3:0][16:0]   w1_curn_reg;
    logic signed [32:0] w1_m1_reg, w1_m2_reg;
    logic signed [31:0] w1_sl_reg;
    base_t              w1_next;

    always_comb begin
        w1_next = ph.b;
        // Remaining angle already within the limit when cos(limit) < cos(remaining).
        if (!ph.dec) begin
            if ($signed(33'(cl)) < $signed(33'(ph.c))) begin
                w1_next.oc = qrt_pkg::OC_REACHED;
            end else begin
                w1_next.oc = qrt_pkg::OC_PARTIAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            w1_reg.vld <= w1_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            w1_reg.cur  <= w1_next.cur;
            w1_reg.tgt  <= w1_next.tgt;
            w1_reg.oc   <= w1_next.oc;
            w1_curn_reg <= ph.curn;
            w1_m1_reg   <= 33'(qrt_pkg::mul_q30($signed(34'(s_root)), 34'(cl)));
            w1_m2_reg   <= 33'(qrt_pkg::mul_q30($signed(34'(ph.c)), 34'(sl)));
            w1_sl_reg   <= sl;
        end
    end

    // --------------------------------------------------------- W2: slerp weights a, b
    base_t              w2_reg;
    logic [3:0][16:0]   w2_curn_reg;
    logic signed [32:0] w2_a_reg;
    logic signed [31:0] w2_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w2_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            w2_reg.vld <= w1_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            w2_reg.cur  <= w1_reg.cur;
            w2_reg.tgt  <= w1_reg.tgt;
            w2_reg.oc   <= w1_reg.oc;
            w2_curn_reg <= w1_curn_reg;
            w2_a_reg    <= w1_m1_reg - w1_m2_reg;
            w2_b_reg    <= w1_sl_reg;
        end
    end

    // ------------------------------------------------------- V1: weighted components
    base_t            v1_reg;
    logic [3:0][49:0] v1_pa_reg;
    logic [3:0][47:0] v1_pb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            v1_reg.vld <= w2_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            v1_reg.cur <= w2_reg.cur;
            v1_reg.tgt <= w2_reg.tgt;
            v1_reg.oc  <= w2_reg.oc;
            for (int i = 0; i < 4; i++) begin
                v1_pa_reg[i] <= 50'(w2_a_reg * $signed(w2_curn_reg[i]));
                v1_pb_reg[i] <= 48'(w2_b_reg * $signed(w2_reg.tgt[i]));
            end
        end
    end

    // ------------------------------------------------------ V2: sum, sign, magnitude
    base_t            v2_reg;
    logic [3:0]       v2_sgn_reg;
    logic [3:0][50:0] v2_mag_reg;
    logic [3:0][50:0] vsum;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            vsum[i] = 51'($signed(v1_pa_reg[i])) + 51'($signed(v1_pb_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            v2_reg.vld <= v1_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            v2_reg.cur <= v1_reg.cur;
            v2_reg.tgt <= v1_reg.tgt;
            v2_reg.oc  <= v1_reg.oc;
            for (int i = 0; i < 4; i++) begin
                v2_sgn_reg[i] <= vsum[i][50];
                v2_mag_reg[i] <= vsum[i][50] ? 51'(-vsum[i]) : vsum[i];
            end
        end
    end

    // ---------------------------------------- N1: common right shift to fit 30 bits
    base_t            n1_reg;
    logic [3:0]       n1_sgn_reg;
    logic [3:0][50:0] n1_mag_reg;
    logic [4:0]       n1_sh_reg;
    logic [50:0]      orw;
    logic [4:0]       sh_next;

    // The largest magnitude has the same bit length as the OR of all four.
    always_comb begin
        orw     = v2_mag_reg[0] | v2_mag_reg[1] | v2_mag_reg[2] | v2_mag_reg[3];
        sh_next = '0;
        for (int i = 30; i < 51; i++) begin
            if (orw[i]) begin
                sh_next = 5'(i - 29);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            n1_reg.vld <= v2_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n1_reg.cur <= v2_reg.cur;
            n1_reg.tgt <= v2_reg.tgt;
            n1_reg.oc  <= v2_reg.oc;
            n1_sgn_reg <= v2_sgn_reg;
            n1_mag_reg <= v2_mag_reg;
            n1_sh_reg  <= sh_next;
        end
    end

    // ---------------------------------------------------------------- N2: shift
    tail_t n2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_reg.b.vld <= 1'b0;
        end else if (pipe_en) begin
            n2_reg.b.vld <= n1_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n2_reg.b.cur <= n1_reg.cur;
            n2_reg.b.tgt <= n1_reg.tgt;
            n2_reg.b.oc  <= n1_reg.oc;
            n2_reg.sgn   <= n1_sgn_reg;
            for (int i = 0; i < 4; i++) begin
                n2_reg.mag[i] <= 30'(n1_mag_reg[i] >> n1_sh_reg);
            end
        end
    end

    // --------------------------------------------------------------- N3: squares
    tail_t            n3_reg;
    logic [3:0][59:0] n3_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n3_reg.b.vld <= 1'b0;
        end else if (pipe_en) begin
            n3_reg.b.vld <= n2_reg.b.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n3_reg.b.cur <= n2_reg.b.cur;
            n3_reg.b.tgt <= n2_reg.b.tgt;
            n3_reg.b.oc  <= n2_reg.b.oc;
            n3_reg.sgn   <= n2_reg.sgn;
            n3_reg.mag   <= n2_reg.mag;
            for (int i = 0; i < 4; i++) begin
                n3_sq_reg[i] <= 60'(n2_reg.mag[i]) * 60'(n2_reg.mag[i]);
            end
        end
    end

    // ----------------------------------------------------------- N4: sum of squares
    tail_t                         n4_reg;
    logic [qrt_pkg::SQRT_IN_W-1:0] n4_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n4_reg.b.vld <= 1'b0;
        end else if (pipe_en) begin
            n4_reg.b.vld <= n3_reg.b.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n4_reg.b.cur <= n3_reg.b.cur;
            n4_reg.b.tgt <= n3_reg.b.tgt;
            n4_reg.b.oc  <= n3_reg.b.oc;
            n4_reg.sgn   <= n3_reg.sgn;
            n4_reg.mag   <= n3_reg.mag;
            n4_sum_reg   <= qrt_pkg::SQRT_IN_W'(n3_sq_reg[0]) + qrt_pkg::SQRT_IN_W'(n3_sq_reg[1])
                          + qrt_pkg::SQRT_IN_W'(n3_sq_reg[2]) + qrt_pkg::SQRT_IN_W'(n3_sq_reg[3]);
        end
    end

    // ------------------------------------------------------------------ vector length
    logic [qrt_pkg::SQRT_W-1:0] norm;
    tail_t                      tl;

    qrt_isqrt #(.IN_W(qrt_pkg::SQRT_IN_W)) u_sqrt_len (
        .aclk (aclk),
        .en   (pipe_en),
        .rad  (n4_sum_reg),
        .root (norm)
    );

    qrt_delay #(.W($bits(tail_t)), .N(qrt_pkg::SQRT_W)) u_tail_pad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .din     (n4_reg),
        .dout    (tl)
    );

    // ------------------------------------------------- D0: rounded dividends, divide
    fin_t                                 d0_reg;
    logic [3:0][qrt_pkg::NUM_W-1:0]       d0_num_reg;
    logic [qrt_pkg::SQRT_W-1:0]           d0_den_reg;
    logic [3:0][qrt_pkg::QUO_W-1:0]       quo;
    fin_t                                 fn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_reg.b.vld <= 1'b0;
        end else if (pipe_en) begin
            d0_reg.b.vld <= tl.b.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d0_reg.b.cur <= tl.b.cur;
            d0_reg.b.tgt <= tl.b.tgt;
            d0_reg.b.oc  <= tl.b.oc;
            d0_reg.sgn   <= tl.sgn;
            d0_reg.nz    <= (norm != '0);
            d0_den_reg   <= norm;
            for (int i = 0; i < 4; i++) begin
                d0_num_reg[i] <= (qrt_pkg::NUM_W'(tl.mag[i]) << F)
                               + qrt_pkg::NUM_W'(norm >> 1);
            end
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_div
        qrt_div #(
            .NUM_W (qrt_pkg::NUM_W),
            .DEN_W (qrt_pkg::SQRT_W),
            .QUO_W (qrt_pkg::QUO_W)
        ) u_div (
            .aclk (aclk),
            .en   (pipe_en),
            .num  (d0_num_reg[i]),
            .den  (d0_den_reg),
            .quo  (quo[i])
        );
    end

    qrt_delay #(.W($bits(fin_t)), .N(qrt_pkg::QUO_W)) u_fin_pad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .din     (d0_reg),
        .dout    (fn)
    );

    // ------------------------------------------- output register: select and saturate
    logic [3:0][15:0] res_next;
    logic [3:0][15:0] slerp_res;
    logic [31:0]      q32;
    logic [63:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q32 = 32'(quo[i]);
            if (!fn.nz) begin
                slerp_res[i] = '0;
            end else if (fn.sgn[i]) begin
                slerp_res[i] = (q32 > 32'd32768) ? 16'h8000 : 16'(-q32);
            end else begin
                slerp_res[i] = (q32 > 32'd32767) ? 16'h7fff : 16'(q32);
            end
        end
        case (fn.b.oc)
            qrt_pkg::OC_NONE:    res_next = fn.b.cur;
            qrt_pkg::OC_REACHED: res_next = fn.b.tgt;
            qrt_pkg::OC_PARTIAL: res_next = slerp_res;
            default:             res_next = slerp_res;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= fn.b.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_tdata_reg <= res_next;
            m_tuser_reg <= fn.b.oc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== tb/tb_quaternion_rotate_towards_limited_core.sv =====
// Self-checking testbench for the limited quaternion rotate-towards pipeline.
module tb_quaternion_rotate_towards_limited_core;

    localparam longint Q30 = longint'(1) << 30;
    localparam longint Q30_HALFPI = 1686629713;
    localparam int RAND_REQUESTS = 1035;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [63:0]        quat;
        qrt_pkg::outcome_t  oc;
    } turn_t;

    typedef struct packed {
        logic [143:0]       req;
        bit                 known;
        logic [63:0]        quat;
        qrt_pkg::outcome_t  oc;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // s_tdata from bit 0: cur_w, cur_x, cur_y, cur_z, tgt_w, tgt_x, tgt_y, tgt_z, step_limit
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // m_tdata from bit 0: res_w, res_x, res_y, res_z
    logic [63:0]  m_tdata;
    // m_tuser from bit 0: outcome
    logic [1:0]   m_tuser;

    turn_t pending_turns[$];
    int    mismatches = 0;
    int    accepted = 0;
    bit    sending_done = 0;

    quaternion_rotate_towards_limited_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Q30 product rounded half away from zero.
    function automatic longint round_mul(input longint x, input longint y);
        longint p;
        p = x * y;
        if (p < 0) return -((-p + (Q30 >>> 1)) / Q30);
        return (p + (Q30 >>> 1)) / Q30;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val) bitv >>= 2;
        while (bitv != 0) begin
            if (val >= root + bitv) begin
                val -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Expected turned quaternion for one request.
    function automatic turn_t predict_turn(input logic [143:0] req);
        longint cur[4], tgt[4], v[4];
        logic [15:0] res[4];
        longint unsigned mag[4];
        longint unsigned lim, full, dm, m, sum, n, q;
        longint d, c, l30, s, sl, cl, a, b, x2, t;
        int sh;
        turn_t r;
        d = 0;
        for (int i = 0; i < 4; i++) begin
            cur[i] = longint'($signed(req[16*i +: 16]));
            tgt[i] = longint'($signed(req[64 + 16*i +: 16]));
            d += cur[i] * tgt[i];
        end
        lim = req[143:128];
        full = 64'd1 << (2 * qrt_pkg::FRAC_BITS);
        r.quat = req[63:0];
        r.oc = qrt_pkg::OC_NONE;
        // A step limit below one milliradian leaves current untouched.
        if (lim * 1000 < (64'd1 << qrt_pkg::FRAC_BITS)) return r;
        r.quat = req[127:64];
        r.oc = qrt_pkg::OC_REACHED;
        if (d > 0 && longint'(d) >= longint'(full - full / 10000)) return r;
        // Short path: flip current so the dot product is non-negative.
        if (d < 0) begin
            for (int i = 0; i < 4; i++) cur[i] = -cur[i];
            d = -d;
        end
        dm = d;
        if (dm >= full) c = Q30;
        else if (2 * qrt_pkg::FRAC_BITS >= 30) c = dm >> (2 * qrt_pkg::FRAC_BITS - 30);
        else c = dm << (30 - 2 * qrt_pkg::FRAC_BITS);
        l30 = lim << (30 - qrt_pkg::FRAC_BITS);
        if (l30 > Q30_HALFPI) return r;
        x2 = round_mul(l30, l30);
        t = Q30;
        for (int k = 8; k >= 1; k--) t = Q30 - round_mul(x2, t) / ((2*k - 1) * (2*k));
        cl = t;
        // Remaining angle already within the limit.
        if (cl < c) return r;
        t = Q30;
        for (int k = 7; k >= 1; k--) t = Q30 - round_mul(x2, t) / ((2*k) * (2*k + 1));
        sl = round_mul(l30, t);
        s = int_sqrt(longint'(Q30 * Q30) - c * c);
        a = round_mul(s, cl) - round_mul(c, sl);
        b = sl;
        m = 0;
        for (int i = 0; i < 4; i++) begin
            v[i] = a * cur[i] + b * tgt[i];
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
            if (mag[i] > m) m = mag[i];
        end
        sh = 0;
        while (sh < 63 && (m >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] >>= sh;
            sum += mag[i] * mag[i];
        end
        n = int_sqrt(sum);
        for (int i = 0; i < 4; i++) begin
            if (n == 0) begin
                // Degenerate length gives an all-zero quaternion.
                res[i] = 16'd0;
            end else begin
                q = ((mag[i] << qrt_pkg::FRAC_BITS) + n / 2) / n;
                if (v[i] < 0) res[i] = (q > 32768) ? 16'h8000 : 16'(-longint'(q));
                else res[i] = (q > 32767) ? 16'h7fff : 16'(q);
            end
        end
        r.quat = {res[3], res[2], res[1], res[0]};
        r.oc = qrt_pkg::OC_PARTIAL;
        return r;
    endfunction

    function automatic logic [143:0] pack_req(input int cw, cx, cy, cz, tw, tx, ty, tz,
                                               input int lim);
        return {16'(lim), 16'(tz), 16'(ty), 16'(tx), 16'(tw),
                16'(cz), 16'(cy), 16'(cx), 16'(cw)};
    endfunction

    // Random unit quaternion in Q2.14, optionally a small perturbation of a base.
    function automatic logic [63:0] unit_quat(input logic [63:0] base, input int spread);
        real comp[4];
        real norm;
        logic [63:0] q;
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
            if (spread > 0)
                comp[i] = real'($signed(base[16*i +: 16])) +
                          real'(int'($urandom_range(0, 2*spread)) - spread);
            else
                comp[i] = real'(int'($urandom_range(0, 65535)) - 32768);
            norm += comp[i] * comp[i];
        end
        if (norm < 1.0) return 64'h0000_0000_0000_4000;
        norm = $sqrt(norm);
        for (int i = 0; i < 4; i++) q[16*i +: 16] = 16'($rtoi(comp[i] * 16384.0 / norm));
        return q;
    endfunction

    function automatic logic [143:0] random_req();
        logic [63:0] cq, tq;
        logic [15:0] lim;
        int pick;
        pick = $urandom_range(0, 99);
        // Raw bits cover every input bit and non-unit inputs.
        if (pick < 15) return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        cq = unit_quat(64'd0, 0);
        if (pick < 45) tq = unit_quat(64'd0, 0);
        else tq = unit_quat(cq, (pick < 70) ? 400 : 4000);
        // Opposite sign on the target exercises the short path.
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 4; i++) tq[16*i +: 16] = -tq[16*i +: 16];
        case ($urandom_range(0, 3))
            0: lim = $urandom_range(0, 40);
            1: lim = $urandom_range(17, 2000);
            2: lim = $urandom_range(2000, 26000);
            default: lim = $urandom;
        endcase
        return {lim, tq, cq};
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got, exp_v);
        $display("MISMATCH %s: got %h expected %h", field, got, exp_v);
        mismatches++;
    endtask

    // Sender: directed table first, then random requests; after 19% of accepted requests it idles,
    // except for a back-to-back stretch in the middle of the random part.
    task automatic offer_request(input logic [143:0] req, input turn_t typed, input bit known);
        s_tvalid <= 1'b1;
        s_tdata <= req;
        do @(posedge aclk); while (!s_tready);
        pending_turns.push_back(known ? typed : predict_turn(req));
        accepted++;
        if ((accepted < 500 || accepted > 700) && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        row_t rows[$];
        turn_t typed;
        rows.push_back('{pack_req(16384, 0, 0, 0, 16384, 0, 0, 0, 0), 1,
                         64'h0000_0000_0000_4000, qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16), 1,
                         64'h0000_0000_0000_4000, qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, 0, 16384, 0, 0, 17), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, 16384, 0, 0, 0, 17), 1,
                         64'h0000_0000_0000_4000, qrt_pkg::OC_REACHED});
        rows.push_back('{pack_req(16384, 0, 0, 0, 0, 16384, 0, 0, 65535), 1,
                         64'h0000_0000_4000_0000, qrt_pkg::OC_REACHED});
        rows.push_back('{pack_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16384), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, -16384, 0, 0, 0, 8192), 1,
                         64'h0000_0000_0000_c000, qrt_pkg::OC_REACHED});
        rows.push_back('{pack_req(-32768, -32768, -32768, -32768,
                                  32767, 32767, 32767, 32767, 8000), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767, 100), 1,
                         64'h7fff_7fff_7fff_7fff, qrt_pkg::OC_REACHED});
        rows.push_back('{pack_req(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 65535), 1,
                         64'h8000_8000_8000_8000, qrt_pkg::OC_REACHED});
        // Zero inputs with a real step collapse to a zero-length result.
        rows.push_back('{pack_req(0, 0, 0, 0, 0, 0, 0, 0, 20000), 1, 64'd0,
                         qrt_pkg::OC_PARTIAL});
        rows.push_back('{pack_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 64'd0, qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(0, 0, 0, 16384, 0, 16384, 0, 0, 17), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, 11585, 11585, 0, 0, 4096), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(16384, 0, 0, 0, -11585, 0, 11585, 0, 3000), 0, '0,
                         qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(32767, -32768, 0, 1, -1, 0, 32767, -32768, 65535),
                         0, '0, qrt_pkg::OC_NONE});
        rows.push_back('{pack_req(11585, 0, 11585, 0, 11585, 0, 11584, 1, 25000),
                         0, '0, qrt_pkg::OC_NONE});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            typed.quat = rows[i].quat;
            typed.oc = rows[i].oc;
            offer_request(rows[i].req, typed, rows[i].known);
        end
        for (int i = 0; i < RAND_REQUESTS; i++) offer_request(random_req(), '0, 0);
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Receiver: random back-pressure, a quiet stretch, and one long hold-off that fills
    // the pipeline so the input side must stall.
    initial begin
        int cycles;
        turn_t exp_t;
        cycles = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_turns.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[15:0], 16'd0);
                end else begin
                    exp_t = pending_turns.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[16*i +: 16] !== exp_t.quat[16*i +: 16])
                            report_mismatch($sformatf("res component %0d", i),
                                            m_tdata[16*i +: 16], exp_t.quat[16*i +: 16]);
                    if (m_tuser !== exp_t.oc)
                        report_mismatch("outcome", 16'(m_tuser), 16'(exp_t.oc));
                end
            end
            cycles++;
            if (cycles >= 600 && cycles < 900) m_tready <= 1'b0;
            else if (cycles >= 1800 && cycles < 2300) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 32);
        end
    end

    initial begin
        wait (sending_done);
        while (pending_turns.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qrt_pkg.sv
rtl/qrt_delay.sv
rtl/qrt_trig.sv
rtl/qrt_isqrt.sv
rtl/qrt_div.sv
rtl/quaternion_rotate_towards_limited_core.sv
tb/tb_quaternion_rotate_towards_limited_core.sv
